// ----- src/dhcp_client_session_fsm_unit_macros.svh -----
// assertion macros shared by the dhcp client session controller
`ifndef DHCP_CLIENT_SESSION_FSM_UNIT_MACROS_SVH
`define DHCP_CLIENT_SESSION_FSM_UNIT_MACROS_SVH

// condition implies consequence in the same cycle
`define DCSF_ASSERT_SAME(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (cons)) \
    else $error("dcsf same-cycle check failed");

// condition implies consequence in the next cycle
`define DCSF_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (cons)) \
    else $error("dcsf next-cycle check failed");

`endif

// ----- src/dcsf_pkg.sv -----
// shared types and codes of the dhcp client session controller
package dcsf_pkg;

  // event kinds
  localparam logic [1:0] KIND_REPLY  = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_TIMER  = 2'd2;
  localparam logic [1:0] KIND_CANCEL = 2'd3;

  // dhcp message types
  localparam logic [7:0] MT_OFFER    = 8'd2;
  localparam logic [7:0] MT_ACK      = 8'd5;
  localparam logic [1:0] MT_DISCOVER = 2'd1;
  localparam logic [1:0] MT_REQUEST  = 2'd3;
  localparam logic [1:0] MT_NONE     = 2'd0;

  // result actions
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_TX      = 3'd1;
  localparam logic [2:0] ACT_OK      = 3'd2;
  localparam logic [2:0] ACT_TIMEOUT = 3'd3;
  localparam logic [2:0] ACT_CANCEL  = 3'd4;

  // stored-as codes
  localparam logic [1:0] STORED_NONE  = 2'd0;
  localparam logic [1:0] STORED_STD   = 2'd1;
  localparam logic [1:0] STORED_PROXY = 2'd2;

  // configuration register indexes
  localparam logic CFG_CLIENT_XID = 1'b0;
  localparam logic CFG_PROXY_WAIT = 1'b1;

  localparam logic [15:0] PROXY_WAIT_RESET = 16'd2000;

  // classified item passed from front to back
  typedef struct packed {
    logic [1:0] kind;
    logic       xid_match;
    logic       is_offer;
    logic       is_ack;
    logic       addr_zero;
    logic [7:0] prio;
    logic       no_proxy;
    logic       timer_fail;
  } cmd_t;

  // result item
  typedef struct packed {
    logic [2:0] action;
    logic [1:0] tx_msgtype;
    logic       reply_accepted;
    logic [1:0] stored_as;
    logic       use_proxy;
  } res_t;

  // queue status seen by its neighbours
  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage

// ----- src/dcsf_front.sv -----
// front end: classifies an incoming event against the expected transaction id
module dcsf_front import dcsf_pkg::*; (
  input  logic [1:0]  req_type_i,
  input  logic [31:0] pkt_xid_i,
  input  logic        pkt_addr_zero_i,
  input  logic [7:0]  pkt_msgtype_i,
  input  logic [7:0]  pkt_priority_i,
  input  logic        pkt_no_proxy_i,
  input  logic        timer_fail_i,
  input  logic [31:0] client_xid_i,
  output cmd_t        cmd_o
);

  // reduce the wide compares to flags for the back end
  always_comb begin
    cmd_o.kind       = req_type_i;
    cmd_o.xid_match  = (pkt_xid_i == client_xid_i);
    cmd_o.is_offer   = (pkt_msgtype_i == MT_OFFER);
    cmd_o.is_ack     = (pkt_msgtype_i == MT_ACK);
    cmd_o.addr_zero  = pkt_addr_zero_i;
    cmd_o.prio       = pkt_priority_i;
    cmd_o.no_proxy   = pkt_no_proxy_i;
    cmd_o.timer_fail = timer_fail_i;
  end

endmodule

// ----- src/dcsf_cmd_queue.sv -----
// two-entry queue of classified items between front and back
module dcsf_cmd_queue import dcsf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  cmd_t    data_i,
  input  logic    pop_i,
  output q_stat_t stat_o,
  output cmd_t    data_o
);

  cmd_t       mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  // handshake qualification
  assign do_push = push_i && (cnt_q != 2'd2);
  assign do_pop  = pop_i && (cnt_q != 2'd0);

  // pointer and count update
  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // item storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o       = mem_q[rd_q];
  assign stat_o.valid = (cnt_q != 2'd0);
  assign stat_o.full  = (cnt_q == 2'd2);

endmodule

// ----- src/dcsf_back.sv -----
// back end: session state update and result queue
module dcsf_back import dcsf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  q_stat_t     cmd_stat_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  input  logic [15:0] proxy_wait_i,
  input  logic        res_pop_i,
  output logic        res_empty_o,
  output res_t        res_o
);

  localparam logic [1:0] PH_DISCOVER = 2'd0;
  localparam logic [1:0] PH_REQUEST  = 2'd1;
  localparam logic [1:0] PH_DONE     = 2'd2;

  logic [1:0]  phase_q, phase_d;
  logic        have_std_q, have_std_d;
  logic [7:0]  std_prio_q, std_prio_d;
  logic        std_np_q, std_np_d;
  logic        have_px_q, have_px_d;
  logic [7:0]  px_prio_q, px_prio_d;
  logic [31:0] ticks_q, ticks_d;

  res_t        out_mem_q [2];
  logic        out_wr_q, out_rd_q;
  logic [1:0]  out_cnt_q, out_cnt_d;
  logic        out_pop;

  res_t        res;
  logic        active, in_disc, in_req, accept;
  logic        wait_over;

  // take an item whenever the result queue has room
  assign cmd_pop_o = cmd_stat_i.valid && (out_cnt_q != 2'd2);
  assign out_pop   = res_pop_i && (out_cnt_q != 2'd0);

  assign in_disc   = (phase_q == PH_DISCOVER);
  assign in_req    = (phase_q == PH_REQUEST);
  assign active    = in_disc || in_req;
  assign accept    = cmd_i.xid_match &&
                     ((in_disc && cmd_i.is_offer) || (in_req && cmd_i.is_ack));
  assign wait_over = (ticks_q > {16'd0, proxy_wait_i});

  // event execution
  always_comb begin
    phase_d    = phase_q;
    have_std_d = have_std_q;
    std_prio_d = std_prio_q;
    std_np_d   = std_np_q;
    have_px_d  = have_px_q;
    px_prio_d  = px_prio_q;
    ticks_d    = ticks_q;
    res        = '0;
    if (cmd_i.kind == KIND_TICK) begin
      if (ticks_q != '1) begin
        ticks_d = ticks_q + 32'd1;
      end
    end else if (active) begin
      case (cmd_i.kind)
        KIND_REPLY: begin
          if (accept) begin
            res.reply_accepted = 1'b1;
            // keep the reply in its slot when priority allows
            if (cmd_i.addr_zero) begin
              if (!have_px_q || (cmd_i.prio >= px_prio_q)) begin
                have_px_d     = 1'b1;
                px_prio_d     = cmd_i.prio;
                res.stored_as = STORED_PROXY;
              end
            end else begin
              if (!have_std_q || (cmd_i.prio >= std_prio_q)) begin
                have_std_d    = 1'b1;
                std_prio_d    = cmd_i.prio;
                std_np_d      = cmd_i.no_proxy;
                res.stored_as = STORED_STD;
              end
            end
            // phase advance once a standard reply is held (in discover only with no_proxy or the proxy wait over)
            if (have_std_d) begin
              if (in_disc) begin
                if (std_np_d || wait_over) begin
                  phase_d        = PH_REQUEST;
                  res.action     = ACT_TX;
                  res.tx_msgtype = MT_REQUEST;
                end
              end else begin
                res.action    = ACT_OK;
                res.use_proxy = have_px_d && !std_np_d;
                phase_d       = PH_DONE;
              end
            end
          end
        end
        KIND_TIMER: begin
          if (cmd_i.timer_fail) begin
            res.action = ACT_TIMEOUT;
            phase_d    = PH_DONE;
          end else begin
            res.action     = ACT_TX;
            res.tx_msgtype = in_disc ? MT_DISCOVER : MT_REQUEST;
          end
        end
        KIND_CANCEL: begin
          res.action = ACT_CANCEL;
          phase_d    = PH_DONE;
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

  // result queue occupancy
  always_comb begin
    out_cnt_d = out_cnt_q;
    if (cmd_pop_o && !out_pop) begin
      out_cnt_d = out_cnt_q + 2'd1;
    end else if (out_pop && !cmd_pop_o) begin
      out_cnt_d = out_cnt_q - 2'd1;
    end
  end

  // session state, updated only when an item is executed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_DISCOVER;
      have_std_q <= 1'b0;
      std_prio_q <= 8'd0;
      std_np_q   <= 1'b0;
      have_px_q  <= 1'b0;
      px_prio_q  <= 8'd0;
      ticks_q    <= 32'd0;
      out_wr_q   <= 1'b0;
      out_rd_q   <= 1'b0;
      out_cnt_q  <= 2'd0;
    end else begin
      if (cmd_pop_o) begin
        phase_q    <= phase_d;
        have_std_q <= have_std_d;
        std_prio_q <= std_prio_d;
        std_np_q   <= std_np_d;
        have_px_q  <= have_px_d;
        px_prio_q  <= px_prio_d;
        ticks_q    <= ticks_d;
        out_wr_q   <= ~out_wr_q;
      end
      if (out_pop) begin
        out_rd_q <= ~out_rd_q;
      end
      out_cnt_q <= out_cnt_d;
    end
  end

  // result storage
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      out_mem_q[out_wr_q] <= res;
    end
  end

  assign res_o       = out_mem_q[out_rd_q];
  assign res_empty_o = (out_cnt_q == 2'd0);

endmodule

// ----- src/dhcp_client_session_fsm_unit.sv -----
// top level of the dhcp client session controller
//
// channel  direction  handshake            payload
// events   in         push / full          req_type_i, pkt_*_i, timer_fail_i
// results  out        empty / pop          action_o, tx_msgtype_o, reply_accepted_o,
//                                          stored_as_o, use_proxy_o
// config   in         cfg_we_i (no wait)   cfg_idx_i, cfg_data_i
//
// one item per cycle sustained while the result queue has room; an item pushed
// is written into the event queue, executed from it into the result queue when
// that has room, and its result can then be popped; both queues hold two items
// each, and the session state register update in the back end executes an item
// reset clears the session and loads client_xid 0, proxy_wait_ticks 2000
// with pop held low the result queue fills, then the event queue, then full rises
`include "dhcp_client_session_fsm_unit_macros.svh"

module dhcp_client_session_fsm_unit import dcsf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] pkt_xid_i,
  input  logic        pkt_addr_zero_i,
  input  logic [7:0]  pkt_msgtype_i,
  input  logic [7:0]  pkt_priority_i,
  input  logic        pkt_no_proxy_i,
  input  logic        timer_fail_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  action_o,
  output logic [1:0]  tx_msgtype_o,
  output logic        reply_accepted_o,
  output logic [1:0]  stored_as_o,
  output logic        use_proxy_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] client_xid_q;
  logic [15:0] proxy_wait_q;
  cmd_t        front_cmd, q_cmd;
  q_stat_t     q_stat;
  logic        q_pop;
  res_t        res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      client_xid_q <= 32'd0;
      proxy_wait_q <= PROXY_WAIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CLIENT_XID: client_xid_q <= cfg_data_i;
        CFG_PROXY_WAIT: proxy_wait_q <= cfg_data_i[15:0];
        default: client_xid_q <= client_xid_q;
      endcase
    end
  end

  // classify incoming events
  dcsf_front u_front (
    .req_type_i      (req_type_i),
    .pkt_xid_i       (pkt_xid_i),
    .pkt_addr_zero_i (pkt_addr_zero_i),
    .pkt_msgtype_i   (pkt_msgtype_i),
    .pkt_priority_i  (pkt_priority_i),
    .pkt_no_proxy_i  (pkt_no_proxy_i),
    .timer_fail_i    (timer_fail_i),
    .client_xid_i    (client_xid_q),
    .cmd_o           (front_cmd)
  );

  // decoupling queue
  dcsf_cmd_queue u_cmd_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_cmd),
    .pop_i  (q_pop),
    .stat_o (q_stat),
    .data_o (q_cmd)
  );

  assign full = q_stat.full;

  // session execution
  dcsf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_stat_i   (q_stat),
    .cmd_i        (q_cmd),
    .cmd_pop_o    (q_pop),
    .proxy_wait_i (proxy_wait_q),
    .res_pop_i    (pop),
    .res_empty_o  (empty),
    .res_o        (res)
  );

  assign action_o         = res.action;
  assign tx_msgtype_o     = res.tx_msgtype;
  assign reply_accepted_o = res.reply_accepted;
  assign stored_as_o      = res.stored_as;
  assign use_proxy_o      = res.use_proxy;

  // checks on result consistency and queue behaviour
  `DCSF_ASSERT_SAME(a_store_needs_accept, clk_i, rst_ni, !empty && (stored_as_o != STORED_NONE), reply_accepted_o)
  `DCSF_ASSERT_SAME(a_txtype_only_on_tx, clk_i, rst_ni, !empty && (action_o != ACT_TX), tx_msgtype_o == MT_NONE)
  `DCSF_ASSERT_SAME(a_proxy_only_on_ok, clk_i, rst_ni, !empty && use_proxy_o, action_o == ACT_OK)
  `DCSF_ASSERT_NEXT(a_exec_fills_results, clk_i, rst_ni, q_pop, !empty)

endmodule
